>>> rtl/core/rna_pkg.sv
// Package for the rational number ALU: word types, mode codes, state codes.
// No dependencies; every module of the block imports it.
package rna_pkg;

    localparam int DW = 64;          // internal datapath width
    localparam int XW = 32;          // field width of operands

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_NEG  = 3'd4,
        MODE_NORM = 3'd5,
        MODE_CMP  = 3'd6,
        MODE_INT  = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        PH_OPA,
        PH_OPB,
        PH_FINAL
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_RED_G,
        S_RED_GW,
        S_RED_N,
        S_RED_NW,
        S_RED_D,
        S_RED_DW,
        S_STORE,
        S_DISP,
        S_ADD_G,
        S_ADD_GW,
        S_ADD_T1,
        S_ADD_T1W,
        S_ADD_T2,
        S_ADD_T2W,
        S_MUL,
        S_COMB,
        S_INT,
        S_INTW,
        S_OUT
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_equal;
        logic               is_less;
        logic signed [31:0] int_part;
        logic               zero_den_error;
        logic               overflow;
    } t_res_word;

    // Sign-extend the low w bits of x to 32 bits.
    function automatic logic [XW-1:0] sext_w(input logic [XW-1:0] x, input int w);
        logic [XW-1:0] r;
        for (int i = 0; i < XW; i++) begin
            r[i] = (i < w) ? x[i] : x[w-1];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/rna_gcd.sv
// Binary GCD unit: one subtract-or-shift step per cycle on 64-bit magnitudes.
// Depends on rna_pkg.
module rna_gcd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_x,
    input  logic [63:0]         i_y,
    output logic                o_done,
    output logic [63:0]         o_g
);
    import rna_pkg::*;

    logic [DW-1:0] r_u, r_v, r_g;
    logic [5:0]    r_k;
    logic          r_busy, r_done;
    logic [DW-1:0] diff_uv, diff_vu;
    logic          u_ge_v;

    assign diff_uv = r_u - r_v;
    assign diff_vu = r_v - r_u;
    assign u_ge_v  = r_u >= r_v;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_u == '0 || r_v == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Step datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u <= i_x;
            r_v <= i_y;
            r_k <= '0;
        end else if (r_busy) begin
            if (r_u == '0) begin
                r_g <= r_v << r_k;
            end else if (r_v == '0) begin
                r_g <= r_u << r_k;
            end else if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 6'd1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (u_ge_v) begin
                r_u <= diff_uv >> 1;
            end else begin
                r_v <= diff_vu >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

>>> rtl/core/rna_div.sv
// Restoring divider: 64-bit unsigned quotient, one bit per cycle.
// Depends on rna_pkg. Divisor must be nonzero.
module rna_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_num,
    input  logic [63:0]         i_den,
    output logic                o_done,
    output logic [63:0]         o_quo
);
    import rna_pkg::*;

    logic [DW-1:0] r_rem, r_q, r_d;
    logic [5:0]    r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   trial;
    logic          take;

    assign trial = {r_rem, r_q[DW-1]};
    assign take  = trial >= {1'b0, r_d};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-subtract step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_d   <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? DW'(trial - {1'b0, r_d}) : trial[DW-1:0];
            r_q   <= {r_q[DW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

>>> rtl/core/rational_number_alu_unit.sv
// Rational ALU top: sequencer around a shared GCD unit, divider and 32x32 multiplier.
// Each reduction is one binary GCD followed by two divisions; a new word is accepted only
// while the sequencer is idle, so words are processed one at a time.
// Busy is high from the accept edge until the result strobe; the strobe lasts one cycle.
// Synchronous active-low reset returns the sequencer to idle; no clearing pass.
module rational_number_alu_unit #(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  rna_pkg::t_in_word   i_in,
    output logic                busy,
    output logic                o_valid,
    output rna_pkg::t_res_word  o_res
);
    import rna_pkg::*;

    t_state        r_state, n_state;
    t_phase        r_phase;
    t_in_word      r_in;
    t_res_word     r_res;
    logic          r_valid;

    logic          r_a_neg, r_b_neg;
    logic [31:0]   r_a_num, r_a_den, r_b_num, r_b_den;
    logic [31:0]   r_t1, r_t2;
    logic [DW-1:0] r_n, r_d, r_g, r_qn, r_qd, r_rn, r_rd;
    logic          r_neg, r_rneg, r_err, r_eq, r_lt;
    logic [DW-1:0] r_p [3];
    logic [1:0]    r_mcnt;

    logic          use_b, accept;
    logic [31:0]   src_num, src_den, sx_num, sx_den, nm, dm;
    logic          gcd_start, gcd_done, div_start, div_done;
    logic [DW-1:0] gcd_x, gcd_y, gcd_g, div_n, div_d, div_q;
    logic [31:0]   mul_x, mul_y;
    logic [DW-1:0] mul_p;
    logic [1:0]    mul_last;
    logic          red_neg;
    logic [DW-1:0] half, wrap_v;
    logic          fits_v;
    logic [31:0]   wrapped;
    logic [30:0]   den_masked;

    assign accept = start && !busy;
    assign use_b  = (r_in.mode == MODE_ADD) || (r_in.mode == MODE_SUB) ||
                    (r_in.mode == MODE_MUL) || (r_in.mode == MODE_DIV) ||
                    (r_in.mode == MODE_CMP);

    // Operand magnitudes after sign extension from WIDTH bits
    assign src_num = (r_phase == PH_OPB) ? r_in.b_num : r_in.a_num;
    assign src_den = (r_phase == PH_OPB) ? r_in.b_den : r_in.a_den;
    assign sx_num  = sext_w(src_num, WIDTH);
    assign sx_den  = sext_w(src_den, WIDTH);
    assign nm      = sx_num[31] ? 32'(-sx_num) : sx_num;
    assign dm      = sx_den[31] ? 32'(-sx_den) : sx_den;
    assign red_neg = r_neg && (r_qn != '0);

    // Shared unit operand selection
    assign gcd_x = (r_state == S_ADD_G) ? DW'(r_a_den) : r_n;
    assign gcd_y = (r_state == S_ADD_G) ? DW'(r_b_den) : r_d;

    always_comb begin
        div_n = r_n;
        div_d = r_g;
        case (r_state)
            S_RED_D:  div_n = r_d;
            S_ADD_T1: div_n = DW'(r_b_den);
            S_ADD_T2: div_n = DW'(r_a_den);
            S_INT: begin
                div_n = DW'(r_a_num);
                div_d = DW'(r_a_den);
            end
            default: ;
        endcase
    end

    always_comb begin
        mul_x    = r_a_num;
        mul_y    = r_b_den;
        mul_last = 2'd1;
        case (r_in.mode)
            MODE_ADD, MODE_SUB: begin
                mul_last = 2'd2;
                case (r_mcnt)
                    2'd0: begin
                        mul_x = r_a_num;
                        mul_y = r_t1;
                    end
                    2'd1: begin
                        mul_x = r_b_num;
                        mul_y = r_t2;
                    end
                    default: begin
                        mul_x = r_t2;
                        mul_y = r_b_den;
                    end
                endcase
            end
            MODE_MUL: begin
                mul_x = (r_mcnt == 2'd0) ? r_a_num : r_a_den;
                mul_y = (r_mcnt == 2'd0) ? r_b_num : r_b_den;
            end
            default: begin
                mul_x = (r_mcnt == 2'd0) ? r_a_num : r_a_den;
                mul_y = (r_mcnt == 2'd0) ? r_b_den : r_b_num;
            end
        endcase
    end
    assign mul_p = DW'(mul_x) * DW'(mul_y);

    // Result range check and wrap
    assign half   = DW'(1) << (WIDTH - 1);
    assign fits_v = r_rneg ? (r_rn <= half) : (r_rn < half);
    assign wrap_v = r_rneg ? DW'(-r_rn) : r_rn;
    assign wrapped = sext_w(wrap_v[31:0], WIDTH);
    always_comb begin
        for (int i = 0; i < 31; i++) begin
            den_masked[i] = (i < WIDTH - 1) ? r_rd[i] : 1'b0;
        end
    end

    // Next state and unit starts
    always_comb begin
        n_state   = r_state;
        gcd_start = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE:    if (start) n_state = S_LOAD;
            S_LOAD:    n_state = (dm == '0) ? S_STORE : S_RED_G;
            S_RED_G: begin
                gcd_start = 1'b1;
                n_state   = S_RED_GW;
            end
            S_RED_GW:  if (gcd_done) n_state = S_RED_N;
            S_RED_N: begin
                div_start = 1'b1;
                n_state   = S_RED_NW;
            end
            S_RED_NW:  if (div_done) n_state = S_RED_D;
            S_RED_D: begin
                div_start = 1'b1;
                n_state   = S_RED_DW;
            end
            S_RED_DW:  if (div_done) n_state = S_STORE;
            S_STORE: begin
                if (r_phase == PH_FINAL) begin
                    n_state = S_OUT;
                end else if (r_phase == PH_OPA && use_b) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_in.mode)
                    MODE_ADD, MODE_SUB: n_state = S_ADD_G;
                    MODE_MUL, MODE_CMP: n_state = S_MUL;
                    MODE_DIV:           n_state = (r_b_num == '0) ? S_OUT : S_MUL;
                    MODE_INT:           n_state = S_INT;
                    default:            n_state = S_OUT;
                endcase
            end
            S_ADD_G: begin
                gcd_start = 1'b1;
                n_state   = S_ADD_GW;
            end
            S_ADD_GW:  if (gcd_done) n_state = S_ADD_T1;
            S_ADD_T1: begin
                div_start = 1'b1;
                n_state   = S_ADD_T1W;
            end
            S_ADD_T1W: if (div_done) n_state = S_ADD_T2;
            S_ADD_T2: begin
                div_start = 1'b1;
                n_state   = S_ADD_T2W;
            end
            S_ADD_T2W: if (div_done) n_state = S_MUL;
            S_MUL:     if (r_mcnt == mul_last) n_state = S_COMB;
            S_COMB:    n_state = (r_in.mode == MODE_CMP) ? S_OUT : S_RED_G;
            S_INT: begin
                div_start = 1'b1;
                n_state   = S_INTW;
            end
            S_INTW:    if (div_done) n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_in  <= i_in;
                    r_err <= 1'b0;
                    r_eq  <= 1'b0;
                    r_lt  <= 1'b0;
                    r_phase <= PH_OPA;
                end
            end
            S_LOAD: begin
                if (dm == '0) begin
                    r_err <= 1'b1;
                    r_neg <= sx_num[31];
                    r_qn  <= DW'(nm != '0);
                    r_qd  <= DW'(1);
                end else begin
                    r_n   <= DW'(nm);
                    r_d   <= DW'(dm);
                    r_neg <= sx_num[31] ^ sx_den[31];
                end
            end
            S_RED_GW:  if (gcd_done) r_g <= gcd_g;
            S_RED_NW:  if (div_done) r_qn <= div_q;
            S_RED_DW:  if (div_done) r_qd <= div_q;
            S_STORE: begin
                case (r_phase)
                    PH_OPA: begin
                        r_a_neg <= red_neg;
                        r_a_num <= r_qn[31:0];
                        r_a_den <= r_qd[31:0];
                        r_phase <= PH_OPB;
                    end
                    PH_OPB: begin
                        r_b_neg <= (r_in.mode == MODE_SUB) ? (!red_neg && r_qn != '0)
                                                           : red_neg;
                        r_b_num <= r_qn[31:0];
                        r_b_den <= r_qd[31:0];
                    end
                    default: begin
                        r_rn   <= r_qn;
                        r_rd   <= r_qd;
                        r_rneg <= red_neg;
                    end
                endcase
            end
            S_DISP: begin
                r_mcnt <= '0;
                r_phase <= PH_FINAL;
                r_rn   <= DW'(r_a_num);
                r_rd   <= DW'(r_a_den);
                r_rneg <= (r_in.mode == MODE_NEG) ? (!r_a_neg && r_a_num != '0) : r_a_neg;
                if (r_in.mode == MODE_DIV && r_b_num == '0) begin
                    r_err <= 1'b1;
                end
            end
            S_ADD_GW:  if (gcd_done) r_g <= gcd_g;
            S_ADD_T1W: if (div_done) r_t1 <= div_q[31:0];
            S_ADD_T2W: if (div_done) r_t2 <= div_q[31:0];
            S_MUL: begin
                r_p[r_mcnt] <= mul_p;
                r_mcnt      <= r_mcnt + 2'd1;
            end
            S_COMB: begin
                case (r_in.mode)
                    MODE_CMP: begin
                        if ((r_a_neg && r_p[0] != '0) != (r_b_neg && r_p[1] != '0)) begin
                            r_eq <= 1'b0;
                            r_lt <= r_a_neg && r_p[0] != '0;
                        end else begin
                            r_eq <= r_p[0] == r_p[1];
                            r_lt <= (r_a_neg && r_p[0] != '0) ? (r_p[0] > r_p[1])
                                                              : (r_p[0] < r_p[1]);
                        end
                    end
                    MODE_ADD, MODE_SUB: begin
                        r_d <= r_p[2];
                        if (r_a_neg == r_b_neg) begin
                            r_n   <= r_p[0] + r_p[1];
                            r_neg <= r_a_neg;
                        end else if (r_p[0] >= r_p[1]) begin
                            r_n   <= r_p[0] - r_p[1];
                            r_neg <= r_a_neg;
                        end else begin
                            r_n   <= r_p[1] - r_p[0];
                            r_neg <= r_b_neg;
                        end
                    end
                    default: begin
                        r_n   <= r_p[0];
                        r_d   <= r_p[1];
                        r_neg <= r_a_neg ^ r_b_neg;
                    end
                endcase
            end
            S_INTW: begin
                if (div_done) begin
                    r_rn   <= div_q;
                    r_rneg <= r_a_neg && div_q != '0;
                end
            end
            S_OUT: begin
                r_res.zero_den_error <= r_err;
                r_res.is_equal       <= (r_in.mode == MODE_CMP) && r_eq;
                r_res.is_less        <= (r_in.mode == MODE_CMP) && r_lt;
                case (r_in.mode)
                    MODE_CMP: begin
                        r_res.res_num  <= '0;
                        r_res.res_den  <= 31'd1;
                        r_res.int_part <= '0;
                        r_res.overflow <= 1'b0;
                    end
                    MODE_INT: begin
                        r_res.res_num  <= '0;
                        r_res.res_den  <= 31'd1;
                        r_res.int_part <= wrapped;
                        r_res.overflow <= !fits_v;
                    end
                    default: begin
                        r_res.res_num  <= wrapped;
                        r_res.res_den  <= den_masked;
                        r_res.int_part <= '0;
                        r_res.overflow <= !fits_v || (r_rd >= half);
                    end
                endcase
            end
            default: ;
        endcase
    end

    rna_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_x     (gcd_x),
        .i_y     (gcd_y),
        .o_done  (gcd_done),
        .o_g     (gcd_g)
    );

    rna_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held longer than one cycle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("accepted word did not raise busy");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.overflow |-> o_res.res_den != '0)
        else $error("zero denominator without overflow");
    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !gcd_done && !div_done)
        else $error("shared unit finished while sequencer idle");

endmodule

>>> bench/tb_rational_number_alu_unit.sv
// Testbench for rational_number_alu_unit: directed and random words in all eight modes,
// with every result checked field by field against a predictor held in the scoreboard.
// Depends on rna_pkg (word types, mode codes) and on the RTL of the block.
module tb_rational_number_alu_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rna_pkg::*;

    localparam int  W          = 32;
    localparam int  N_RANDOM   = 700;
    localparam int  TAIL_WAIT  = 3000;
    localparam longint LIMIT   = 6000000;
    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;

    // Fraction held as sign and magnitudes
    typedef struct {
        bit          neg;
        bit [63:0]   num;
        bit [63:0]   den;
    } t_frac;

    // Scoreboard: predicts the result of each accepted word, checks results in order
    class rat_scoreboard;
        t_res_word expected_q[$];
        int        mismatches;
        int        unexpected;

        function bit [63:0] gcd(bit [63:0] x, bit [63:0] y);
            bit [63:0] t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function t_frac reduce(bit neg, bit [63:0] n, bit [63:0] d);
            t_frac r;
            bit [63:0] g;
            if (d == 0) d = 1;
            g = gcd(n, d);
            if (g == 0) g = 1;
            r.num = n / g;
            r.den = d / g;
            r.neg = neg && (r.num != 0);
            return r;
        endfunction

        function t_frac operand(logic [31:0] rn, logic [31:0] rd, inout bit err);
            t_frac r;
            bit nneg, dneg;
            bit [63:0] nm, dm;
            nneg = rn[31];
            dneg = rd[31];
            nm = nneg ? 64'(-$signed(64'(signed'(rn)))) : 64'(rn);
            dm = dneg ? 64'(-$signed(64'(signed'(rd)))) : 64'(rd);
            if (dm == 0) begin
                err = 1;
                r.neg = nneg && (nm != 0);
                r.num = (nm != 0) ? 64'd1 : 64'd0;
                r.den = 1;
                return r;
            end
            return reduce(nneg != dneg, nm, dm);
        endfunction

        function t_frac add_frac(t_frac a, t_frac b);
            bit [63:0] g, n1, n2, d;
            g  = gcd(a.den, b.den);
            n1 = a.num * (b.den / g);
            n2 = b.num * (a.den / g);
            d  = (a.den / g) * b.den;
            if (a.neg == b.neg) return reduce(a.neg, n1 + n2, d);
            if (n1 >= n2) return reduce(a.neg, n1 - n2, d);
            return reduce(b.neg, n2 - n1, d);
        endfunction

        function t_frac mul_frac(t_frac a, t_frac b);
            return reduce(a.neg != b.neg, a.num * b.num, a.den * b.den);
        endfunction

        function bit fits(bit neg, bit [63:0] mag);
            return neg ? (mag <= (64'd1 << (W - 1))) : (mag < (64'd1 << (W - 1)));
        endfunction

        function logic [31:0] wrap(bit neg, bit [63:0] mag);
            bit [63:0] v;
            v = neg ? (64'd0 - mag) : mag;
            return v[31:0];
        endfunction

        // Note an accepted word: push its predicted result
        function void note_word(t_in_word w);
            t_res_word e;
            t_frac a, b, r, rc;
            bit err, use_b;
            bit [63:0] p, q, qm;
            bit pn, qn;
            err = 0;
            e = '0;
            e.res_den = 31'd1;
            a = operand(w.a_num, w.a_den, err);
            b.neg = 0; b.num = 0; b.den = 1;
            use_b = (w.mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_CMP});
            if (use_b) b = operand(w.b_num, w.b_den, err);
            if (w.mode == MODE_CMP) begin
                // cross products decide order
                p  = a.num * b.den;
                q  = b.num * a.den;
                pn = a.neg && (p != 0);
                qn = b.neg && (q != 0);
                e.is_equal = (pn == qn) && (p == q);
                if (pn != qn) e.is_less = pn;
                else e.is_less = pn ? (p > q) : (p < q);
            end else if (w.mode == MODE_INT) begin
                qm = a.num / a.den;
                qn = a.neg && (qm != 0);
                e.overflow = !fits(qn, qm);
                e.int_part = wrap(qn, qm);
            end else begin
                case (w.mode)
                    MODE_ADD: r = add_frac(a, b);
                    MODE_SUB: begin
                        b.neg = !b.neg && (b.num != 0);
                        r = add_frac(a, b);
                    end
                    MODE_MUL: r = mul_frac(a, b);
                    MODE_DIV: begin
                        // division by zero: reciprocal falls back to 1/1
                        if (b.num == 0) begin
                            err = 1;
                            rc.neg = 0; rc.num = 1; rc.den = 1;
                        end else begin
                            rc.neg = b.neg; rc.num = b.den; rc.den = b.num;
                        end
                        r = mul_frac(a, rc);
                    end
                    MODE_NEG: begin
                        r = a;
                        r.neg = !a.neg && (a.num != 0);
                    end
                    default: r = a;
                endcase
                e.overflow = !fits(r.neg, r.num) || (r.den >= (64'd1 << (W - 1)));
                e.res_num  = wrap(r.neg, r.num);
                e.res_den  = r.den[30:0];
            end
            e.zero_den_error = err;
            expected_q.push_back(e);
        endfunction

        // Check one result word against the oldest prediction
        function void check_word(t_res_word got);
            t_res_word e;
            if (expected_q.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.res_num !== e.res_num || got.res_den !== e.res_den ||
                got.is_equal !== e.is_equal || got.is_less !== e.is_less ||
                got.int_part !== e.int_part || got.zero_den_error !== e.zero_den_error ||
                got.overflow !== e.overflow) begin
                mismatches++;
                if (mismatches + unexpected <= 10)
                    $display("mismatch: exp num=%0d den=%0d eq=%b lt=%b int=%0d zd=%b ov=%b | got num=%0d den=%0d eq=%b lt=%b int=%0d zd=%b ov=%b",
                             e.res_num, e.res_den, e.is_equal, e.is_less, e.int_part,
                             e.zero_den_error, e.overflow,
                             got.res_num, got.res_den, got.is_equal, got.is_less,
                             got.int_part, got.zero_den_error, got.overflow);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_word  i_in = '0;
    logic      busy;
    logic      o_valid;
    t_res_word o_res;
    longint    cycles = 0;
    rat_scoreboard sb;

    rational_number_alu_unit #(.WIDTH(W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #6 i_clk = ~i_clk;

    // Cycle count and hang guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[rational_number_alu_unit] ERROR");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_word(o_res);
    end

    // Issue one word after a random idle gap, return once it is accepted
    task automatic send_word(t_in_word w);
        int gap;
        gap = $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        sb.note_word(w);
    endtask

    task automatic send4(t_mode m, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd);
        t_in_word w;
        w.mode = m; w.a_num = an; w.a_den = ad; w.b_num = bn; w.b_den = bd;
        send_word(w);
    endtask

    // Operand value drawn from a mix of classes
    function automatic logic [31:0] rand_val();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 32'($urandom_range(0, 24)) - 32'd12;
            4, 5:       v = $urandom;
            6: case ($urandom_range(0, 4))
                   0: v = MIN32;
                   1: v = MAX32;
                   2: v = 32'd0;
                   3: v = 32'd1;
                   default: v = 32'hFFFF_FFFF;
               endcase
            7: begin
                v = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            8: v = (32'($urandom_range(1, 60)) << $urandom_range(0, 20))
                   * ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    initial begin
        t_in_word w;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, zero denominators, division by zero, every mode
        send4(MODE_ADD,  32'd1, 32'd2, 32'd1, 32'd3);
        send4(MODE_ADD,  MAX32, 32'd1, MAX32, 32'd1);
        send4(MODE_ADD,  MIN32, 32'd1, MIN32, 32'd1);
        send4(MODE_SUB,  32'd3, 32'd4, 32'd3, 32'd4);
        send4(MODE_SUB,  MIN32, 32'd1, 32'd1, 32'd1);
        send4(MODE_MUL,  MIN32, 32'd1, MIN32, 32'd1);
        send4(MODE_MUL,  32'd6, 32'hFFFF_FFF7, 32'd3, 32'd4);
        send4(MODE_MUL,  32'd1, MAX32, 32'd1, MAX32);
        send4(MODE_DIV,  32'd5, 32'd7, 32'd0, 32'd9);
        send4(MODE_DIV,  MAX32, 32'd1, 32'd1, MAX32);
        send4(MODE_DIV,  32'd1, MIN32, 32'hFFFF_FFFF, 32'd1);
        send4(MODE_NEG,  MIN32, 32'd1, 32'd0, 32'd0);
        send4(MODE_NEG,  32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send4(MODE_NORM, 32'd12, 32'hFFFF_FFF8, 32'd0, 32'd0);
        send4(MODE_NORM, 32'hFFFF_FFF9, 32'd0, 32'd5, 32'd0);
        send4(MODE_NORM, 32'd0, 32'd0, 32'd0, 32'd0);
        send4(MODE_NORM, MIN32, MIN32, 32'd0, 32'd0);
        send4(MODE_CMP,  32'd1, 32'd2, 32'd2, 32'd4);
        send4(MODE_CMP,  32'hFFFF_FFFF, 32'd3, 32'd1, 32'd3);
        send4(MODE_CMP,  MAX32, MIN32, MIN32, MAX32);
        send4(MODE_CMP,  32'd5, 32'd0, 32'd7, 32'd0);
        send4(MODE_INT,  MIN32, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send4(MODE_INT,  32'hFFFF_FFF9, 32'd2, 32'd0, 32'd0);
        send4(MODE_INT,  MAX32, 32'd1, 32'd0, 32'd0);
        send4(MODE_INT,  32'd3, 32'd0, 32'd0, 32'd0);

        // Random words
        repeat (N_RANDOM) begin
            w.mode  = t_mode'($urandom_range(0, 7));
            w.a_num = rand_val();
            w.a_den = rand_val();
            w.b_num = rand_val();
            w.b_den = rand_val();
            send_word(w);
        end
        start <= 1'b0;

        // Drain, then a quiet tail
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.expected_q.size() == 0) begin
            $display("[rational_number_alu_unit] OK");
        end else begin
            $display("[rational_number_alu_unit] ERROR");
        end
        $finish;
    end
endmodule

>>> rational_number_alu_unit.f
rtl/core/rna_pkg.sv
rtl/core/rna_gcd.sv
rtl/core/rna_div.sv
rtl/core/rational_number_alu_unit.sv
bench/tb_rational_number_alu_unit.sv
